// ===== hdl/bnas_pkg.sv =====
// ----------------------------------------------------------------------------
// bnas_pkg
// Shared types and constants for the Boolean network attractor search core.
// ----------------------------------------------------------------------------
package bnas_pkg;

  localparam int INT_VARS  = 6;
  localparam int EXT_VARS  = 8;
  localparam int CLAUSES   = 8;
  localparam int SLOTS     = INT_VARS * CLAUSES;
  localparam int STATES    = 1 << INT_VARS;
  localparam int LIT_W     = INT_VARS + EXT_VARS;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  localparam logic [1:0] CFG_INTERNAL_COUNT = 2'd0;
  localparam logic [1:0] CFG_EXTERNAL_COUNT = 2'd1;
  localparam logic [1:0] CFG_HAS_RULE_MASK  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [2:0]  target_var;
    logic [2:0]  clause_slot;
    logic        clause_in_use;
    logic [13:0] positive_mask;
    logic [13:0] negative_mask;
    logic [7:0]  scene_bits;
    logic [3:0]  scene_length;
  } bnas_in_t;

  typedef struct packed {
    logic [6:0] attractor_number;
    logic [5:0] state_bits;
    logic       last_of_attractor;
    logic       last_of_run;
  } bnas_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DRAIN, S_COPY, S_PICK, S_STEP,
    S_NEXT, S_POS, S_EMIT, S_WEND, S_FINISH
  } bnas_state_t;

  typedef struct packed {
    logic load;
    logic run_init;
    logic eval_issue;
    logic copy_step;
    logic pick_skip;
    logic walk_begin;
    logic walk_step;
    logic walk_adv;
    logic found;
    logic pos_load;
    logic emit_issue;
    logic walk_end;
    logic finish;
  } bnas_cmd_t;

  typedef struct packed {
    logic eval_last;
    logic copy_last;
    logic k_done;
    logic start_visited;
    logic nxt_on_path;
    logic nxt_visited;
    logic emit_last;
  } bnas_stat_t;

endpackage

// ===== hdl/bnas_ctrl.sv =====
// ----------------------------------------------------------------------------
// bnas_ctrl
// Sequencer: rule evaluation, map copy, graph walk and attractor emission.
// ----------------------------------------------------------------------------
module bnas_ctrl
  import bnas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       func,
  input  bnas_stat_t stat,
  output bnas_cmd_t  cmd,
  output logic       busy
);

  bnas_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start && func == FUNC_RUN) state_nxt = S_EVAL;
      S_EVAL:   if (stat.eval_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_COPY;
      S_COPY:   if (stat.copy_last) state_nxt = S_PICK;
      S_PICK: begin
        if (stat.k_done) state_nxt = S_FINISH;
        else if (!stat.start_visited) state_nxt = S_STEP;
      end
      S_STEP:   state_nxt = S_NEXT;
      S_NEXT: begin
        if (stat.nxt_on_path) state_nxt = S_POS;
        else if (stat.nxt_visited) state_nxt = S_WEND;
        else state_nxt = S_STEP;
      end
      S_POS:    state_nxt = S_EMIT;
      S_EMIT:   if (stat.emit_last) state_nxt = S_WEND;
      S_WEND:   state_nxt = S_PICK;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load     = start && func == FUNC_LOAD;
        cmd.run_init = start && func == FUNC_RUN;
      end
      S_EVAL:   cmd.eval_issue = 1'b1;
      S_COPY:   cmd.copy_step  = 1'b1;
      S_PICK: begin
        cmd.pick_skip  = !stat.k_done && stat.start_visited;
        cmd.walk_begin = !stat.k_done && !stat.start_visited;
      end
      S_STEP:   cmd.walk_step = 1'b1;
      S_NEXT: begin
        cmd.found    = stat.nxt_on_path;
        cmd.walk_adv = !stat.nxt_on_path && !stat.nxt_visited;
      end
      S_POS:    cmd.pos_load   = 1'b1;
      S_EMIT:   cmd.emit_issue = 1'b1;
      S_WEND:   cmd.walk_end   = 1'b1;
      S_FINISH: cmd.finish     = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== hdl/bnas_dpath.sv =====
// ----------------------------------------------------------------------------
// bnas_dpath
// Clause store, per-variable rule lanes, next-state map, walk and result regs.
// ----------------------------------------------------------------------------
module bnas_dpath
  import bnas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata,
  input  bnas_in_t   in_data,
  input  bnas_cmd_t  cmd,
  output bnas_stat_t stat,
  output logic       out_valid,
  output bnas_out_t  out_data
);

  logic [2:0] int_cnt_r;
  logic [3:0] ext_cnt_r;
  logic [5:0] rule_mask_r;

  logic [2:0] n_r;
  logic [3:0] ne_r;
  logic [7:0] scene_r;

  logic [2*LIT_W-1:0] clause_mem [0:SLOTS-1];
  logic [SLOTS-1:0]   clause_valid_r;
  logic [2*LIT_W-1:0] clause_rd_r;
  logic [5:0]         eval_idx_r;
  logic [5:0]         eval_slot_r;
  logic               eval_vld_r;

  logic [STATES-1:0] lane_r [0:INT_VARS-1];
  logic [5:0]        copy_s_r;

  logic [5:0] map_mem   [0:STATES-1];
  logic [6:0] ppos_mem  [0:STATES-1];
  logic [5:0] pstore_mem[0:STATES-1];
  logic [5:0] map_rd_r;
  logic [6:0] ppos_rd_r;
  logic [5:0] pstore_rd_r;

  logic [STATES-1:0] visited_r;
  logic [STATES-1:0] on_path_r;
  logic [6:0]        k_r;
  logic [5:0]        cur_r;
  logic [6:0]        len_r;
  logic [6:0]        pos_i_r;
  logic [6:0]        attr_r;
  logic              emit_vld_r;
  logic              emit_last_r;

  logic      pend_vld_r;
  bnas_out_t pend_r;
  logic      out_vld_r;
  bnas_out_t out_r;

  logic [6:0]        nstates;
  logic [LIT_W-1:0]  defined;
  logic [STATES-1:0] sat_vec;
  logic [5:0]        rev_k;
  logic [5:0]        start_s;
  logic [5:0]        map_bits;
  logic [2:0]        n_clamp;
  logic [3:0]        ne_cfg;
  logic [3:0]        slen;
  logic [LIT_W-1:0]  pos_m;
  logic [LIT_W-1:0]  neg_m;

  // Effective sizes for a new run.
  always_comb begin
    n_clamp = int_cnt_r;
    if (int_cnt_r == 3'd0) n_clamp = 3'd1;
    else if (int_cnt_r > 3'(INT_VARS)) n_clamp = 3'(INT_VARS);
    ne_cfg = (ext_cnt_r > 4'(EXT_VARS)) ? 4'(EXT_VARS) : ext_cnt_r;
    slen = (in_data.scene_length > 4'(EXT_VARS)) ? 4'(EXT_VARS) : in_data.scene_length;
    if (slen < ne_cfg) ne_cfg = slen;
  end

  assign nstates = 7'd1 << n_r;
  assign defined = {8'((9'd1 << ne_r) - 9'd1), 6'(nstates - 7'd1)};
  assign pos_m   = clause_rd_r[2*LIT_W-1:LIT_W];
  assign neg_m   = clause_rd_r[LIT_W-1:0];

  // One clause against every state at once.
  always_comb begin
    for (int s = 0; s < STATES; s++) begin
      sat_vec[s] = |(((pos_m & {scene_r, 6'(s)}) | (neg_m & ~{scene_r, 6'(s)})) & defined);
    end
  end

  always_comb begin
    for (int b = 0; b < INT_VARS; b++) begin
      rev_k[b]    = k_r[INT_VARS-1-b];
      map_bits[b] = lane_r[b][copy_s_r] & rule_mask_r[b] & (3'(b) < n_r);
    end
  end
  assign start_s = rev_k >> (3'(INT_VARS) - n_r);

  always_comb begin
    stat.eval_last     = eval_idx_r == 6'(SLOTS - 1);
    stat.copy_last     = copy_s_r == 6'(nstates - 7'd1);
    stat.k_done        = k_r == nstates;
    stat.start_visited = visited_r[start_s];
    stat.nxt_on_path   = on_path_r[map_rd_r];
    stat.nxt_visited   = visited_r[map_rd_r];
    stat.emit_last     = pos_i_r + 7'd1 == len_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_cnt_r   <= 3'(INT_VARS);
      ext_cnt_r   <= 4'd0;
      rule_mask_r <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERNAL_COUNT: int_cnt_r   <= cfg_wdata[2:0];
        CFG_EXTERNAL_COUNT: ext_cnt_r   <= cfg_wdata[3:0];
        CFG_HAS_RULE_MASK:  rule_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Memories: write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && in_data.target_var < 3'(INT_VARS)) begin
      clause_mem[{in_data.target_var, in_data.clause_slot}] <=
        {in_data.positive_mask, in_data.negative_mask};
    end
    clause_rd_r <= clause_mem[eval_idx_r];
    if (cmd.copy_step) map_mem[copy_s_r] <= map_bits;
    map_rd_r <= map_mem[cur_r];
    if (cmd.walk_step) begin
      ppos_mem[cur_r]        <= len_r;
      pstore_mem[len_r[5:0]] <= cur_r;
    end
    ppos_rd_r   <= ppos_mem[map_rd_r];
    pstore_rd_r <= pstore_mem[pos_i_r[5:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clause_valid_r <= '0;
    end else if (cmd.load && in_data.target_var < 3'(INT_VARS)) begin
      clause_valid_r[{in_data.target_var, in_data.clause_slot}] <= in_data.clause_in_use;
    end
  end

  // Rule lanes: AND each in-use clause into its variable's lane.
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      for (int v = 0; v < INT_VARS; v++) lane_r[v] <= '1;
    end else if (eval_vld_r && clause_valid_r[eval_slot_r]) begin
      lane_r[eval_slot_r[5:3]] <= lane_r[eval_slot_r[5:3]] & sat_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      n_r     <= n_clamp;
      ne_r    <= ne_cfg;
      scene_r <= in_data.scene_bits;
    end
    if (cmd.walk_begin) cur_r <= start_s;
    else if (cmd.walk_adv) cur_r <= map_rd_r;
    if (cmd.pos_load) pos_i_r <= ppos_rd_r;
    else if (cmd.emit_issue) pos_i_r <= pos_i_r + 7'd1;
    eval_slot_r <= eval_idx_r;
    emit_last_r <= stat.emit_last;
  end

  // Walk control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_idx_r <= 6'd0;
      eval_vld_r <= 1'b0;
      copy_s_r   <= 6'd0;
      visited_r  <= '0;
      on_path_r  <= '0;
      k_r        <= 7'd0;
      len_r      <= 7'd0;
      attr_r     <= 7'd0;
      emit_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= cmd.eval_issue;
      emit_vld_r <= cmd.emit_issue;
      if (cmd.run_init) begin
        eval_idx_r <= 6'd0;
        copy_s_r   <= 6'd0;
        visited_r  <= '0;
        on_path_r  <= '0;
        k_r        <= 7'd0;
        attr_r     <= 7'd0;
      end
      if (cmd.eval_issue) eval_idx_r <= eval_idx_r + 6'd1;
      if (cmd.copy_step) copy_s_r <= copy_s_r + 6'd1;
      if (cmd.pick_skip || cmd.walk_end) k_r <= k_r + 7'd1;
      if (cmd.walk_end) on_path_r <= '0;
      if (cmd.walk_begin) len_r <= 7'd0;
      if (cmd.walk_step) begin
        visited_r[cur_r] <= 1'b1;
        on_path_r[cur_r] <= 1'b1;
        len_r            <= len_r + 7'd1;
      end
      if (cmd.found) attr_r <= attr_r + 7'd1;
    end
  end

  // Hold one result back so the final one of a run can be flagged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= (emit_vld_r || cmd.finish) && pend_vld_r;
      if (cmd.run_init || cmd.finish) pend_vld_r <= 1'b0;
      else if (emit_vld_r) pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld_r) begin
      out_r  <= pend_r;
      pend_r <= '{attractor_number: attr_r, state_bits: pstore_rd_r,
                  last_of_attractor: emit_last_r, last_of_run: 1'b0};
    end else if (cmd.finish) begin
      out_r <= '{attractor_number: pend_r.attractor_number,
                 state_bits: pend_r.state_bits,
                 last_of_attractor: pend_r.last_of_attractor, last_of_run: 1'b1};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/boolean_network_attractor_search_core.sv =====
// ----------------------------------------------------------------------------
// boolean_network_attractor_search_core
// Exhaustive attractor enumeration for a small Boolean network with CNF rules.
// ----------------------------------------------------------------------------
// Load items (func 0) write one clause slot in the cycle they are accepted and
// leave the block idle. A run item (func 1) holds busy high while it works: it
// sweeps the 48-slot clause memory, one slot a cycle, each slot tested against
// all states at once into per-variable lanes; it copies the lanes for all 2^n
// states into the next-state map memory; then the graph walk picks each start
// state, steps through each visited state with a map memory read, closes every
// walk, and for each attractor loads its start position and emits its states.
// Results appear one per strobe on out_valid; the receiver cannot stall, so
// every strobe is a transfer. The last result of a run is held back one
// transfer so it can carry last_of_run, and it is released as busy drops.
module boolean_network_attractor_search_core
  import bnas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  bnas_in_t   in_data,
  output logic       out_valid,
  output bnas_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  bnas_cmd_t  cmd;
  bnas_stat_t stat;

  // Sequencer: accepts items and drives the datapath phases.
  bnas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: clause store, lanes, map, walk state and output registers.
  bnas_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attractor search core: clause loads, scene runs,
// register settings and random traffic, checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
  import bnas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  bnas_in_t   in_data;
  logic       out_valid;
  bnas_out_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_wdata;

  boolean_network_attractor_search_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor state: mirror of the clause memory and the three registers.
  logic [13:0] pm_pos [SLOTS];
  logic [13:0] pm_neg [SLOTS];
  logic        pm_valid [SLOTS];
  logic [2:0]  pm_icount;
  logic [3:0]  pm_ecount;
  logic [5:0]  pm_rules;

  bnas_out_t attractor_q[$];
  int        errors;
  int        cycles;
  localparam int CYCLE_LIMIT = 1000000;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Evaluate one CNF rule for variable v under literal values vals.
  function automatic logic rule_value(input int v, input logic [13:0] vals,
                                      input logic [13:0] defd);
    logic [13:0] sat;
    for (int c = 0; c < CLAUSES; c++) begin
      if (pm_valid[v*CLAUSES+c]) begin
        sat = ((pm_pos[v*CLAUSES+c] & vals) | (pm_neg[v*CLAUSES+c] & ~vals)) & defd;
        if (sat == '0) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Compute every attractor of the scene and queue its states in walk order.
  task automatic predict_attractors(input bnas_in_t it);
    int n, ne, sl, ns, cnt, len, cur, s, total;
    logic [13:0] defd, vals;
    logic [5:0] nmap [STATES];
    bit vis [STATES];
    bit onp [STATES];
    int pos [STATES];
    int path [STATES];
    bnas_out_t r;
    n = (pm_icount < 1) ? 1 : (pm_icount > INT_VARS ? INT_VARS : pm_icount);
    ne = (pm_ecount > EXT_VARS) ? EXT_VARS : pm_ecount;
    sl = (it.scene_length > EXT_VARS) ? EXT_VARS : it.scene_length;
    if (sl < ne) ne = sl;
    ns = 1 << n;
    defd = 14'((ns - 1) | (((1 << ne) - 1) << INT_VARS));
    for (int st = 0; st < ns; st++) begin
      vals = 14'(st) | (14'(it.scene_bits) << INT_VARS);
      nmap[st] = '0;
      for (int v = 0; v < n; v++)
        if (pm_rules[v]) nmap[st][v] = rule_value(v, vals, defd);
      vis[st] = 0;
      onp[st] = 0;
    end
    cnt = 0;
    total = 0;
    for (int k = 0; k < ns; k++) begin
      s = 0;
      for (int b = 0; b < n; b++) s |= ((k >> (n - 1 - b)) & 1) << b;
      if (vis[s]) continue;
      len = 0;
      cur = s;
      while (!vis[cur]) begin
        vis[cur] = 1;
        onp[cur] = 1;
        pos[cur] = len;
        path[len] = cur;
        len++;
        cur = nmap[cur];
        if (onp[cur]) begin
          cnt++;
          for (int i = pos[cur]; i < len; i++) begin
            r.attractor_number = 7'(cnt);
            r.state_bits = 6'(path[i]);
            r.last_of_attractor = (i + 1 == len);
            r.last_of_run = 1'b0;
            attractor_q = {attractor_q, r};
            total++;
          end
          break;
        end
      end
      for (int i = 0; i < len; i++) onp[path[i]] = 0;
    end
    if (total > 0) attractor_q[attractor_q.size()-1].last_of_run = 1'b1;
  endtask

  // Check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    bnas_out_t e;
    if (rst_n && out_valid) begin
      if (attractor_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        e = attractor_q.pop_front();
        if (out_data.attractor_number !== e.attractor_number)
          report_mismatch($sformatf("attractor_number %0d exp %0d",
                                    out_data.attractor_number, e.attractor_number));
        if (out_data.state_bits !== e.state_bits)
          report_mismatch($sformatf("state_bits %0h exp %0h",
                                    out_data.state_bits, e.state_bits));
        if (out_data.last_of_attractor !== e.last_of_attractor)
          report_mismatch("last_of_attractor");
        if (out_data.last_of_run !== e.last_of_run)
          report_mismatch("last_of_run");
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    repeat (g) @(negedge clk);
  endtask

  // Transfer one item: raise start, hold until the block takes it.
  task automatic send_item(input bnas_in_t it);
    @(negedge clk);
    start <= 1'b1;
    in_data <= it;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (it.func == FUNC_LOAD) begin
      if (it.target_var < INT_VARS) begin
        pm_valid[it.target_var*CLAUSES+it.clause_slot] = it.clause_in_use;
        pm_pos[it.target_var*CLAUSES+it.clause_slot] = it.positive_mask;
        pm_neg[it.target_var*CLAUSES+it.clause_slot] = it.negative_mask;
      end
    end else begin
      predict_attractors(it);
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (attractor_q.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INTERNAL_COUNT: pm_icount = val[2:0];
      CFG_EXTERNAL_COUNT: pm_ecount = val[3:0];
      default:            pm_rules = val;
    endcase
  endtask

  function automatic bnas_in_t load_item(input int v, input int c, input bit use_it,
                                         input logic [13:0] p, input logic [13:0] q);
    bnas_in_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(bnas_in_t)-1:0];
    it.func = FUNC_LOAD;
    it.target_var = 3'(v);
    it.clause_slot = 3'(c);
    it.clause_in_use = use_it;
    it.positive_mask = p;
    it.negative_mask = q;
    return it;
  endfunction

  function automatic bnas_in_t run_item(input logic [7:0] sb, input logic [3:0] sl);
    bnas_in_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(bnas_in_t)-1:0];
    it.func = FUNC_RUN;
    it.scene_bits = sb;
    it.scene_length = sl;
    return it;
  endfunction

  // Write every slot so no undefined mask is ever read.
  task automatic test_clear_rules();
    for (int v = 0; v < INT_VARS; v++)
      for (int c = 0; c < CLAUSES; c++)
        send_item(load_item(v, c, 1'b0, '0, '0));
  endtask

  // Directed: no rules, clause-free rules, empty clause, negated rotation, out-of-range loads.
  task automatic test_directed();
    write_reg(CFG_HAS_RULE_MASK, 6'd0);
    send_item(run_item(8'hff, 4'd8));
    write_reg(CFG_HAS_RULE_MASK, 6'h3f);
    send_item(run_item(8'h00, 4'd0));           // rules with no clauses give 1
    send_item(load_item(0, 0, 1'b1, '0, '0));   // empty clause gives 0
    send_item(load_item(6, 0, 1'b1, 14'h3fff, 14'h3fff));  // ignored
    send_item(load_item(7, 7, 1'b1, 14'h3fff, 14'h3fff));  // ignored
    send_item(run_item(8'h00, 4'd0));
    for (int v = 0; v < INT_VARS; v++)           // x(v) <- not x(v+1): rotation
      send_item(load_item(v, 0, 1'b1, '0, 14'(1 << ((v + 1) % INT_VARS))));
    send_item(run_item(8'h55, 4'd15));
    send_item(load_item(1, 7, 1'b1, 14'h3fc0, '0));  // external literals
    write_reg(CFG_EXTERNAL_COUNT, 6'd15);
    send_item(run_item(8'hff, 4'd8));
    send_item(run_item(8'hff, 4'd3));
    write_reg(CFG_INTERNAL_COUNT, 6'd0);
    send_item(run_item(8'h01, 4'd1));
    write_reg(CFG_INTERNAL_COUNT, 6'd7);
    send_item(run_item(8'h80, 4'd8));
    write_reg(CFG_INTERNAL_COUNT, 6'd1);
    send_item(run_item(8'h00, 4'd8));
  endtask

  // Random: loads and runs mixed, with register settings changed between phases.
  task automatic test_random();
    bnas_in_t it;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_INTERNAL_COUNT, 6'($urandom_range(0, 7)));
      write_reg(CFG_EXTERNAL_COUNT, 6'($urandom_range(0, 15)));
      write_reg(CFG_HAS_RULE_MASK, 6'($urandom));
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          it = run_item(8'($urandom), 4'($urandom));
        end else begin
          it = load_item($urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 3) != 0, 14'($urandom), 14'($urandom));
          if ($urandom_range(0, 1) == 0) begin  // sparse literals reach longer cycles
            it.positive_mask &= 14'($urandom);
            it.negative_mask &= 14'($urandom);
          end
        end
        send_item(it);
        if (i == 4) drain();  // hold off until every result has come
        idle_gap();
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pm_icount = 3'd6;
    pm_ecount = 4'd0;
    pm_rules = 6'd0;
    for (int i = 0; i < SLOTS; i++) begin
      pm_pos[i] = '0;
      pm_neg[i] = '0;
      pm_valid[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_clear_rules();
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
